[src/tsjf_pkg.sv]
// Shared types and constants for the touchscreen sample jitter filter.
// Used by the front, queue, back and top-level modules; no dependencies.

package tsjf_pkg;

    localparam int SAMPLE_W = 10;
    localparam int GROUP_SIZE = 4;
    localparam int HOLD_DEPTH = GROUP_SIZE - 1;
    localparam int LIMIT_W = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd10;
    localparam logic REG_IDX_LIMIT = 1'b0;

    localparam logic CMD_CONV = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_MEASURE = 2'd1;
    localparam logic [1:0] ACT_TOUCH = 2'd2;
    localparam logic [1:0] ACT_REJECT = 2'd3;

    localparam logic [1:0] OP_RELEASE = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_GROUP = 2'd2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [1:0] count_t;

    typedef struct packed {
        logic [1:0] op;
        sample_t [GROUP_SIZE-1:0] xs;
        sample_t [GROUP_SIZE-1:0] ys;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        count_t sample_count;
    } front_stat_t;

endpackage

[src/tsjf_front.sv]
// Front end: accepts events, tracks the sample count and holds samples 0 to 2.
// Emits one job per event into the queue. Depends on tsjf_pkg.

module tsjf_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     command,
    input  logic                     pen_up,
    input  tsjf_pkg::sample_t        x_raw,
    input  tsjf_pkg::sample_t        y_raw,
    output tsjf_pkg::job_t           job,
    output tsjf_pkg::front_stat_t    stat
);

    tsjf_pkg::count_t  count_reg;
    tsjf_pkg::count_t  count_next;
    tsjf_pkg::sample_t x_hold_reg [tsjf_pkg::HOLD_DEPTH];
    tsjf_pkg::sample_t y_hold_reg [tsjf_pkg::HOLD_DEPTH];
    logic              store;

    always_comb
    begin
        job.op = tsjf_pkg::OP_MEASURE;
        job.xs = {x_raw, x_hold_reg[2], x_hold_reg[1], x_hold_reg[0]};
        job.ys = {y_raw, y_hold_reg[2], y_hold_reg[1], y_hold_reg[0]};
        count_next = count_reg;
        store = 1'b0;
        if (pen_up)
        begin
            job.op = tsjf_pkg::OP_RELEASE;
            if (command == tsjf_pkg::CMD_CONV)
            begin
                count_next = '0;
            end
        end
        else if (command == tsjf_pkg::CMD_TICK)
        begin
            job.op = tsjf_pkg::OP_MEASURE;
        end
        else if (count_reg == 2'(tsjf_pkg::HOLD_DEPTH))
        begin
            job.op = tsjf_pkg::OP_GROUP;
            count_next = '0;
        end
        else
        begin
            job.op = tsjf_pkg::OP_MEASURE;
            count_next = count_reg + 2'd1;
            store = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tsjf_pkg::HOLD_DEPTH; i++)
        begin
            if (accept && store && count_reg == 2'(i))
            begin
                x_hold_reg[i] <= x_raw;
                y_hold_reg[i] <= y_raw;
            end
        end
    end

    assign stat.sample_count = count_reg;

endmodule

[src/tsjf_queue.sv]
// Two-entry job queue between the front end and the back end.
// Depends on tsjf_pkg for the job type and depth constants.

module tsjf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tsjf_pkg::job_t          job_in,
    input  logic                    pop,
    output tsjf_pkg::job_t          job_out,
    output tsjf_pkg::queue_stat_t   stat
);

    tsjf_pkg::job_t                  mem_reg [tsjf_pkg::QUEUE_DEPTH];
    logic [tsjf_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tsjf_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tsjf_pkg::QLEVEL_W-1:0]   level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out = mem_reg[rd_ptr_reg];
    assign stat.full = (level_reg == tsjf_pkg::QLEVEL_W'(tsjf_pkg::QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);

endmodule

[src/tsjf_back.sv]
// Back end: checks a full group against the deviation limit, forms the mean
// and holds the result in the output register. Depends on tsjf_pkg.

module tsjf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  tsjf_pkg::job_t               job,
    input  logic [tsjf_pkg::LIMIT_W-1:0] error_limit,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   action,
    output tsjf_pkg::sample_t            x_pos,
    output tsjf_pkg::sample_t            y_pos
);

    function automatic logic too_far(
        input tsjf_pkg::sample_t a,
        input tsjf_pkg::sample_t b,
        input tsjf_pkg::sample_t s,
        input logic [tsjf_pkg::LIMIT_W-1:0] limit
    );
        logic [tsjf_pkg::SAMPLE_W:0] sum;
        tsjf_pkg::sample_t           mean;
        tsjf_pkg::sample_t           dev;
        sum = {1'b0, a} + {1'b0, b};
        mean = sum[tsjf_pkg::SAMPLE_W:1];
        dev = (s > mean) ? (s - mean) : (mean - s);
        return dev > limit;
    endfunction

    function automatic tsjf_pkg::sample_t mean4(
        input tsjf_pkg::sample_t [tsjf_pkg::GROUP_SIZE-1:0] v
    );
        logic [tsjf_pkg::SAMPLE_W+1:0] sum;
        sum = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
        return sum[tsjf_pkg::SAMPLE_W+1:2];
    endfunction

    logic              out_valid_reg;
    logic [1:0]        action_reg;
    logic [1:0]        action_next;
    tsjf_pkg::sample_t x_pos_reg;
    tsjf_pkg::sample_t y_pos_reg;
    tsjf_pkg::sample_t x_pos_next;
    tsjf_pkg::sample_t y_pos_next;
    logic              reject;

    assign pop = job_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        reject = too_far(job.xs[0], job.xs[1], job.xs[2], error_limit)
               || too_far(job.ys[0], job.ys[1], job.ys[2], error_limit)
               || too_far(job.xs[1], job.xs[2], job.xs[3], error_limit)
               || too_far(job.ys[1], job.ys[2], job.ys[3], error_limit);
        x_pos_next = '0;
        y_pos_next = '0;
        case (job.op)
            tsjf_pkg::OP_RELEASE:
            begin
                action_next = tsjf_pkg::ACT_RELEASE;
            end
            tsjf_pkg::OP_GROUP:
            begin
                if (reject)
                begin
                    action_next = tsjf_pkg::ACT_REJECT;
                end
                else
                begin
                    action_next = tsjf_pkg::ACT_TOUCH;
                    x_pos_next = mean4(job.xs);
                    y_pos_next = mean4(job.ys);
                end
            end
            default:
            begin
                action_next = tsjf_pkg::ACT_MEASURE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg <= action_next;
            x_pos_reg <= x_pos_next;
            y_pos_reg <= y_pos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = action_reg;
    assign x_pos = x_pos_reg;
    assign y_pos = y_pos_reg;

endmodule

[src/touch_sample_jitter_filter.sv]
// Top level of the touchscreen sample jitter filter: configuration register,
// front end, job queue and back end. Depends on tsjf_pkg and its submodules.
//
//   Channel  Handshake                  Payload
//   in       in_valid / in_stall        command, pen_up, x_raw, y_raw
//   out      out_valid / out_stall      action, x_pos, y_pos
//   cfg      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One item is accepted per cycle while the queue is not full; its result passes through
// the queue register and then the back-end output register before it is offered.
// Reset clears the sample count, the queue and the output valid flag.
// The input stalls only when the two-entry queue is full.

module touch_sample_jitter_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsjf_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsjf_pkg::DATA_W-1:0]   pwdata,
    output logic [tsjf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic                          pen_up,
    input  logic [9:0]                    x_raw,
    input  logic [9:0]                    y_raw,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    action,
    output logic [9:0]                    x_pos,
    output logic [9:0]                    y_pos
);

    logic [tsjf_pkg::LIMIT_W-1:0] limit_reg;
    logic                         in_accept;
    logic                         pop;
    tsjf_pkg::job_t               front_job;
    tsjf_pkg::job_t               head_job;
    tsjf_pkg::queue_stat_t        q_stat;
    tsjf_pkg::front_stat_t        f_stat;
    logic                         reg_sel;

    assign pready = 1'b1;
    assign reg_sel = (paddr[2] == tsjf_pkg::REG_IDX_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tsjf_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            limit_reg <= pwdata[tsjf_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = reg_sel ? tsjf_pkg::DATA_W'(limit_reg) : '0;

    assign in_stall = q_stat.full;
    assign in_accept = in_valid && !in_stall;

    tsjf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .command (command),
        .pen_up  (pen_up),
        .x_raw   (x_raw),
        .y_raw   (y_raw),
        .job     (front_job),
        .stat    (f_stat)
    );

    tsjf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_accept),
        .job_in  (front_job),
        .pop     (pop),
        .job_out (head_job),
        .stat    (q_stat)
    );

    tsjf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!q_stat.empty),
        .job         (head_job),
        .error_limit (limit_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .x_pos       (x_pos),
        .y_pos       (y_pos)
    );

`ifndef NO_ASSERTIONS
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("Queue reports full and empty at once.");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && pen_up && command == tsjf_pkg::CMD_CONV |=> f_stat.sample_count == '0)
        else $error("Conversion with pen up did not clear the sample count.");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != tsjf_pkg::ACT_TOUCH |-> x_pos == '0 && y_pos == '0)
        else $error("Position is nonzero on a result that is not a touch.");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("Back end took a job from an empty queue.");
`endif

endmodule
